// ----- hdl/tcc_pkg.sv -----
// Shared widths and types for the triangle circumcenter pipeline.
// No dependencies; imported by triangle_circumcenter_3d and the bench.
package tcc_pkg;

   // coordinate word, signed fixed point
   localparam int CW   = 32;
   typedef logic signed [CW-1:0] coord_type;

   // edge vectors B-A and C-A
   localparam int DIFW = CW + 1;
   // cross product a x c, and |a|^2, |c|^2 (unsigned)
   localparam int CRW  = 2 * DIFW + 1;
   localparam int SQW  = 2 * DIFW;
   // (a x c) x a and c x (a x c)
   localparam int UVW  = 101;
   // divisor 2|a x c|^2, unsigned
   localparam int DVW  = 134;
   // numerator |c|^2 u + |a|^2 v, signed
   localparam int NW   = UVW + CRW;
   // quotient bits before rounding; the top one flags an offset far out of range
   localparam int QB   = 36;
   // multiplier digit width
   localparam int DIG  = 17;

   // multiplier pipeline: input register, one stage per digit, output register
   localparam int MUL1_LAT = (DIFW + DIG - 1) / DIG + 2;
   localparam int MUL2_LAT = (CRW + DIG - 1) / DIG + 2;

endpackage

// ----- hdl/tcc_dly.sv -----
// Delay line with enable, used to keep side data aligned with the arithmetic.
// No dependencies.
module tcc_dly #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int k = 1; k < N; k++) begin
            sr_ff[k] <= sr_ff[k-1];
         end
      end
   end

   assign q = sr_ff[N-1];

endmodule

// ----- hdl/tcc_mul.sv -----
// Pipelined signed multiplier: one digit of |b| times a per stage.
// No dependencies; an input register and an output register frame the digit stages.
module tcc_mul #(
   parameter int WA  = 33,
   parameter int WB  = 33,
   parameter int DGW = 17
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int ND = (WB + DGW - 1) / DGW;
   localparam int NB = ND * DGW;
   localparam int WP = WA + WB;

   logic signed [WA-1:0] a_ff   [ND];
   logic [NB-1:0]        bm_ff  [ND];
   logic                 neg_ff [ND+1];
   logic signed [WP:0]   acc_ff [ND+1];
   logic signed [WP:0]   pp_in  [ND];
   logic [WB-1:0]        bmag;
   logic signed [WP-1:0] p_ff;

   assign bmag = b[WB-1] ? WB'(-b) : WB'(b);

   for (genvar k = 0; k < ND; k++) begin : g_pp
      logic signed [WA+DGW:0] prod;
      assign prod     = a_ff[k] * $signed({1'b0, bm_ff[k][k*DGW +: DGW]});
      assign pp_in[k] = (WP+1)'(prod) <<< (k * DGW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]   <= a;
         bm_ff[0]  <= NB'(bmag);
         neg_ff[0] <= b[WB-1];
         acc_ff[0] <= '0;
         for (int k = 1; k < ND; k++) begin
            a_ff[k]  <= a_ff[k-1];
            bm_ff[k] <= bm_ff[k-1];
         end
         for (int k = 1; k <= ND; k++) begin
            neg_ff[k] <= neg_ff[k-1];
            acc_ff[k] <= acc_ff[k-1] + pp_in[k-1];
         end
         p_ff <= neg_ff[ND] ? WP'(-acc_ff[ND]) : WP'(acc_ff[ND]);
      end
   end

   assign p = p_ff;

endmodule

// ----- hdl/tcc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounded half up.
// No dependencies; the quotient stages are followed by a rounding output register.
module tcc_div #(
   parameter int NWI = 168,
   parameter int DWI = 134,
   parameter int QBI = 36
) (
   input  logic           clock,
   input  logic           en,
   input  logic [NWI-1:0] mag,
   input  logic [DWI-1:0] d,
   output logic [QBI:0]   off
);

   localparam int RW = ((NWI > DWI + QBI) ? NWI : DWI + QBI) + 1;

   logic [RW-1:0]  rem_ff [QBI];
   logic [DWI-1:0] d_ff   [QBI];
   logic [QBI-1:0] q_ff   [QBI];
   logic [RW-1:0]  rem_in [QBI];
   logic [DWI-1:0] d_in   [QBI];
   logic [QBI-1:0] q_in   [QBI];
   logic [QBI:0]   off_ff;
   logic           rnd;

   for (genvar s = 0; s < QBI; s++) begin : g_step
      logic [RW-1:0]  r_src;
      logic [RW-1:0]  dk;
      logic [DWI-1:0] d_src;
      logic [QBI-1:0] q_src;
      logic           ge;
      if (s == 0) begin : g_first
         assign r_src = RW'(mag);
         assign d_src = d;
         assign q_src = '0;
      end else begin : g_next
         assign r_src = rem_ff[s-1];
         assign d_src = d_ff[s-1];
         assign q_src = q_ff[s-1];
      end
      assign dk        = RW'(d_src) << (QBI - 1 - s);
      assign ge        = (r_src >= dk);
      assign rem_in[s] = ge ? (r_src - dk) : r_src;
      assign d_in[s]   = d_src;
      assign q_in[s]   = {q_src[QBI-2:0], ge};
   end

   // remainder is below the divisor here; round up when it is at least half
   assign rnd = (((DWI+1)'(rem_ff[QBI-1][DWI-1:0])) << 1) >= (DWI+1)'(d_ff[QBI-1]);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QBI; s++) begin
            rem_ff[s] <= rem_in[s];
            d_ff[s]   <= d_in[s];
            q_ff[s]   <= q_in[s];
         end
         off_ff <= (QBI+1)'(q_ff[QBI-1]) + (QBI+1)'(rnd);
      end
   end

   assign off = off_ff;

endmodule

// ----- hdl/triangle_circumcenter_3d.sv -----
// Circumcenter of one 3D triangle per transfer, fully pipelined. With a = B-A and
// c = C-A the block forms A + (|c|^2((a x c) x a) + |a|^2(c x (a x c))) / (2|a x c|^2)
// exactly on the raw coordinate codes, rounds each offset to nearest (ties away
// from zero), adds A and saturates to 32 bits, setting degenerate on saturation.
// A collinear or coincident triangle gives a zero center with degenerate set.
// Throughput is one triangle per clock while no stall is held. The path from the
// input transfer to rsp_valid runs through the multiplier chain (three products
// in series, split into 17-bit digits) and the 36-stage quotient pipeline. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so a stall holds every stage.
// Depends on tcc_pkg, tcc_dly, tcc_mul and tcc_div.
module triangle_circumcenter_3d #(
   parameter int MUL_DIG = tcc_pkg::DIG
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcc_pkg::coord_type  req_ax,
   input  tcc_pkg::coord_type  req_ay,
   input  tcc_pkg::coord_type  req_az,
   input  tcc_pkg::coord_type  req_bx,
   input  tcc_pkg::coord_type  req_by_coord,
   input  tcc_pkg::coord_type  req_bz,
   input  tcc_pkg::coord_type  req_cx,
   input  tcc_pkg::coord_type  req_cy,
   input  tcc_pkg::coord_type  req_cz,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tcc_pkg::coord_type  rsp_center_x,
   output tcc_pkg::coord_type  rsp_center_y,
   output tcc_pkg::coord_type  rsp_center_z,
   output logic                rsp_degenerate
);

   import tcc_pkg::*;

   // pipeline timing, counted in enabled cycles after the input transfer
   localparam int L1    = (DIFW + MUL_DIG - 1) / MUL_DIG + 2;
   localparam int L2    = (CRW + MUL_DIG - 1) / MUL_DIG + 2;
   localparam int L3    = (UVW + MUL_DIG - 1) / MUL_DIG + 2;
   localparam int LD    = QB + 1;
   localparam int T_S2  = 1 + L1 + 1;
   localparam int T_S3  = T_S2 + L2 + 1;
   localparam int T_S4  = T_S3 + L3 + 1;
   localparam int T_S5  = T_S4 + 1;
   localparam int T_DO  = T_S5 + LD;
   localparam int SW    = QB + 3;

   logic en;

   // stage 1: vertex A and edge vectors
   coord_type              base_ff [3];
   logic signed [DIFW-1:0] ea_ff   [3];
   logic signed [DIFW-1:0] ec_ff   [3];
   logic [T_DO-1:0]        vld_ff;

   // stage 2: a x c, |a|^2, |c|^2
   logic signed [SQW-1:0]  crp     [3];
   logic signed [SQW-1:0]  crm     [3];
   logic signed [SQW-1:0]  asq     [3];
   logic signed [SQW-1:0]  csq     [3];
   logic signed [CRW-1:0]  cr_ff   [3];
   logic [SQW-1:0]         aa_ff;
   logic [SQW-1:0]         cc_ff;
   logic [DIFW-1:0]        ead     [3];
   logic [DIFW-1:0]        ecd     [3];

   // stage 3: u, v and the divisor
   logic signed [2*CRW-1:0] up     [3];
   logic signed [2*CRW-1:0] um     [3];
   logic signed [2*CRW-1:0] vp     [3];
   logic signed [2*CRW-1:0] vm     [3];
   logic signed [2*CRW-1:0] dsq    [3];
   logic signed [UVW-1:0]  u_ff    [3];
   logic signed [UVW-1:0]  v_ff    [3];
   logic [DVW-1:0]         d_ff;
   logic [DVW-1:0]         dsum;
   logic [SQW-1:0]         aad;
   logic [SQW-1:0]         ccd;

   // stages 4 and 5: numerators, then magnitude and sign
   logic signed [NW-1:0]   nc      [3];
   logic signed [NW-1:0]   na      [3];
   logic signed [NW-1:0]   n_ff    [3];
   logic [NW-1:0]          mag_ff  [3];
   logic [2:0]             neg_ff;
   logic [DVW-1:0]         d4;
   logic [DVW-1:0]         d5_ff;
   logic                   dz5_ff;

   // quotient and final placement
   logic [QB:0]            off     [3];
   logic [3:0]             side_q;
   logic [CW-1:0]          based   [3];
   logic signed [SW-1:0]   pos     [3];
   logic [2:0]             sat;
   coord_type              res     [3];

   coord_type              center_ff [3];
   logic                   deg_ff;
   logic                   rsp_valid_ff;

   // advance everything when the output register is free or being taken;
   // take no transfer while reset is held
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[T_DO-2:0], req_valid};
         rsp_valid_ff <= vld_ff[T_DO-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff[0] <= req_ax;
         base_ff[1] <= req_ay;
         base_ff[2] <= req_az;
         ea_ff[0]   <= DIFW'(req_bx) - DIFW'(req_ax);
         ea_ff[1]   <= DIFW'(req_by_coord) - DIFW'(req_ay);
         ea_ff[2]   <= DIFW'(req_bz) - DIFW'(req_az);
         ec_ff[0]   <= DIFW'(req_cx) - DIFW'(req_ax);
         ec_ff[1]   <= DIFW'(req_cy) - DIFW'(req_ay);
         ec_ff[2]   <= DIFW'(req_cz) - DIFW'(req_az);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      // products for a x c and the squared lengths
      tcc_mul #(.WA(DIFW), .WB(DIFW), .DGW(MUL_DIG)) u_crp (
         .clock(clock), .en(en), .a(ea_ff[J]), .b(ec_ff[K]), .p(crp[i]));
      tcc_mul #(.WA(DIFW), .WB(DIFW), .DGW(MUL_DIG)) u_crm (
         .clock(clock), .en(en), .a(ea_ff[K]), .b(ec_ff[J]), .p(crm[i]));
      tcc_mul #(.WA(DIFW), .WB(DIFW), .DGW(MUL_DIG)) u_asq (
         .clock(clock), .en(en), .a(ea_ff[i]), .b(ea_ff[i]), .p(asq[i]));
      tcc_mul #(.WA(DIFW), .WB(DIFW), .DGW(MUL_DIG)) u_csq (
         .clock(clock), .en(en), .a(ec_ff[i]), .b(ec_ff[i]), .p(csq[i]));

      // hold the edge vectors until a x c is ready
      tcc_dly #(.W(DIFW), .N(L1 + 1)) u_ead (
         .clock(clock), .en(en), .d(ea_ff[i]), .q(ead[i]));
      tcc_dly #(.W(DIFW), .N(L1 + 1)) u_ecd (
         .clock(clock), .en(en), .d(ec_ff[i]), .q(ecd[i]));

      // (a x c) x a, c x (a x c) and the squared cross product
      tcc_mul #(.WA(CRW), .WB(CRW), .DGW(MUL_DIG)) u_up (
         .clock(clock), .en(en), .a(cr_ff[J]), .b(CRW'($signed(ead[K]))), .p(up[i]));
      tcc_mul #(.WA(CRW), .WB(CRW), .DGW(MUL_DIG)) u_um (
         .clock(clock), .en(en), .a(cr_ff[K]), .b(CRW'($signed(ead[J]))), .p(um[i]));
      tcc_mul #(.WA(CRW), .WB(CRW), .DGW(MUL_DIG)) u_vp (
         .clock(clock), .en(en), .a(cr_ff[K]), .b(CRW'($signed(ecd[J]))), .p(vp[i]));
      tcc_mul #(.WA(CRW), .WB(CRW), .DGW(MUL_DIG)) u_vm (
         .clock(clock), .en(en), .a(cr_ff[J]), .b(CRW'($signed(ecd[K]))), .p(vm[i]));
      tcc_mul #(.WA(CRW), .WB(CRW), .DGW(MUL_DIG)) u_dsq (
         .clock(clock), .en(en), .a(cr_ff[i]), .b(cr_ff[i]), .p(dsq[i]));

      // numerator terms |c|^2 u and |a|^2 v; digits are taken from u and v
      tcc_mul #(.WA(CRW), .WB(UVW), .DGW(MUL_DIG)) u_nc (
         .clock(clock), .en(en), .a($signed({1'b0, ccd})), .b(u_ff[i]), .p(nc[i]));
      tcc_mul #(.WA(CRW), .WB(UVW), .DGW(MUL_DIG)) u_na (
         .clock(clock), .en(en), .a($signed({1'b0, aad})), .b(v_ff[i]), .p(na[i]));

      tcc_div #(.NWI(NW), .DWI(DVW), .QBI(QB)) u_div (
         .clock(clock), .en(en), .mag(mag_ff[i]), .d(d5_ff), .off(off[i]));

      // carry vertex A alongside to the quotient output
      tcc_dly #(.W(CW), .N(T_DO - 1)) u_based (
         .clock(clock), .en(en), .d(base_ff[i]), .q(based[i]));
   end

   tcc_dly #(.W(SQW), .N(L2 + 1)) u_aad (
      .clock(clock), .en(en), .d(aa_ff), .q(aad));
   tcc_dly #(.W(SQW), .N(L2 + 1)) u_ccd (
      .clock(clock), .en(en), .d(cc_ff), .q(ccd));
   tcc_dly #(.W(DVW), .N(L3 + 1)) u_d4 (
      .clock(clock), .en(en), .d(d_ff), .q(d4));
   tcc_dly #(.W(4), .N(LD)) u_side (
      .clock(clock), .en(en), .d({dz5_ff, neg_ff}), .q(side_q));

   assign dsum = DVW'(dsq[0]) + DVW'(dsq[1]) + DVW'(dsq[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cr_ff[i]  <= CRW'(crp[i]) - CRW'(crm[i]);
            u_ff[i]   <= UVW'(up[i]) - UVW'(um[i]);
            v_ff[i]   <= UVW'(vp[i]) - UVW'(vm[i]);
            n_ff[i]   <= nc[i] + na[i];
            mag_ff[i] <= n_ff[i][NW-1] ? NW'(-n_ff[i]) : NW'(n_ff[i]);
            neg_ff[i] <= n_ff[i][NW-1];
         end
         aa_ff  <= SQW'(asq[0]) + SQW'(asq[1]) + SQW'(asq[2]);
         cc_ff  <= SQW'(csq[0]) + SQW'(csq[1]) + SQW'(csq[2]);
         d_ff   <= {dsum[DVW-2:0], 1'b0};
         d5_ff  <= d4;
         dz5_ff <= (d4 == '0);
      end
   end

   // add A to the signed offset and saturate to the coordinate range
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = SW'($signed(based[i])) +
                  (side_q[i] ? -$signed(SW'(off[i])) : $signed(SW'(off[i])));
         sat[i] = !((&pos[i][SW-1:CW-1]) || !(|pos[i][SW-1:CW-1]));
         if (sat[i]) begin
            res[i] = pos[i][SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            res[i] = pos[i][CW-1:0];
         end
      end
   end

   // output register: drop the center for a degenerate triangle
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= side_q[3] ? '0 : res[i];
         end
         deg_ff <= side_q[3] || (|sat);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_x   = center_ff[0];
   assign rsp_center_y   = center_ff[1];
   assign rsp_center_z   = center_ff[2];
   assign rsp_degenerate = deg_ff;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for triangle_circumcenter_3d: drives triangles over the req_
// channel, predicts each circumcenter exactly in wide integers and checks rsp_.
// Depends on tcc_pkg and the block's RTL only.
module tb;
   import tcc_pkg::*;

   localparam int LAT = 60;
   localparam int WW = 400;
   localparam int HOLD_CYCLES = 300;

   typedef logic signed [WW-1:0] wint_type;

   typedef struct {
      coord_type v[9];
   } tri_type;

   typedef struct {
      coord_type x, y, z;
      logic      degen;
   } centre_type;

   localparam wint_type CMAX = wint_type'(2147483647);
   localparam wint_type CMIN = -CMAX - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_v[9] = '{default: '0};
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   coord_type rsp_cx, rsp_cy, rsp_cz;
   logic      rsp_degen;

   tri_type    pending_tris[$];
   centre_type centres_due[$];

   int  mismatches = 0;
   bit  quiet = 1'b0;       // no idling in the final stretch
   bit  hold_req = 1'b0;    // ask the receiver for one long hold-off
   bit  hold_seen = 1'b0;
   int  hold_left = 0;
   bit  req_acc = 1'b0;     // input transfer at the last rising edge
   int  tx_gap = 0;
   int  rx_gap = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   triangle_circumcenter_3d i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ax(req_v[0]), .req_ay(req_v[1]), .req_az(req_v[2]),
      .req_bx(req_v[3]), .req_by_coord(req_v[4]), .req_bz(req_v[5]),
      .req_cx(req_v[6]), .req_cy(req_v[7]), .req_cz(req_v[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_center_x(rsp_cx), .rsp_center_y(rsp_cy), .rsp_center_z(rsp_cz),
      .rsp_degenerate(rsp_degen)
   );

   // Offset n/d rounded to nearest, ties away from zero, added to base, saturated.
   function automatic coord_type place_coord(coord_type base, wint_type n, wint_type d,
                                             inout logic sat);
      wint_type mag, q, r, s;
      mag = (n < 0) ? -n : n;
      q = mag / d;
      r = mag % d;
      if (2 * r >= d) q = q + 1;
      s = base + ((n < 0) ? -q : q);
      if (s > CMAX) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (s < CMIN) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   function automatic centre_type circumcentre(tri_type t);
      wint_type a[3], c[3], cr[3], u[3], v[3], aa, cc, d, n;
      centre_type o;
      coord_type res[3];
      logic sat;
      int j, k;
      for (int i = 0; i < 3; i++) begin
         a[i] = wint_type'(t.v[3+i]) - wint_type'(t.v[i]);
         c[i] = wint_type'(t.v[6+i]) - wint_type'(t.v[i]);
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         cr[i] = a[j] * c[k] - a[k] * c[j];
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         u[i] = cr[j] * a[k] - cr[k] * a[j];
         v[i] = c[j] * cr[k] - c[k] * cr[j];
      end
      aa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      cc = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
      d = 2 * (cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2]);
      if (d == 0) begin
         o.x = '0; o.y = '0; o.z = '0; o.degen = 1'b1;
         return o;
      end
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         n = cc * u[i] + aa * v[i];
         res[i] = place_coord(t.v[i], n, d, sat);
      end
      o.x = res[0]; o.y = res[1]; o.z = res[2]; o.degen = sat;
      return o;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 2047)) - 1024;
         2: return ($signed($urandom_range(0, 65535)) - 32768) <<< 12;
         default: return ($urandom_range(0, 1)) ? 32'sh7fffffff - $urandom_range(0, 3)
                                               : 32'sh80000000 + $urandom_range(0, 3);
      endcase
   endfunction

   // Driver: advance to the next pending triangle at the falling edge once the
   // current one has been taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_acc) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_tris.size() > 0) begin
               tri_type t;
               t = pending_tris.pop_front();
               for (int i = 0; i < 9; i++) req_v[i] <= t.v[i];
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready, with random bursts of back-pressure and one long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 12);
         end
      end
   end

   // Monitor: record each input transfer, and check each result transfer
   // against the oldest expected centre.
   always @(posedge clock) begin
      if (reset) begin
         req_acc <= 1'b0;
      end else begin
         req_acc <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            centres_due.push_back(circumcentre('{v: req_v}));
         end
         if (rsp_valid && rsp_ready) begin
            if (centres_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h %h %h %b",
                                              rsp_cx, rsp_cy, rsp_cz, rsp_degen);
            end else begin
               centre_type e;
               e = centres_due.pop_front();
               if (rsp_cx !== e.x || rsp_cy !== e.y || rsp_cz !== e.z
                   || rsp_degen !== e.degen) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                              e.x, e.y, e.z, e.degen, rsp_cx, rsp_cy, rsp_cz, rsp_degen);
               end
            end
         end
      end
   end

   task automatic add_tri(coord_type p[9]);
      tri_type t;
      for (int i = 0; i < 9; i++) t.v[i] = p[i];
      pending_tris.push_back(t);
   endtask

   task automatic add_random(int n);
      coord_type p[9];
      int mode;
      repeat (n) begin
         mode = $urandom_range(0, 9);
         mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
         for (int i = 0; i < 9; i++) p[i] = rand_coord(mode);
         // occasionally make the triangle collinear or coincident
         if ($urandom_range(0, 19) == 0)
            for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
         add_tri(p);
      end
   endtask

   task automatic wait_drained();
      while (pending_tris.size() > 0 || req_valid || centres_due.size() > 0)
         @(posedge clock);
   endtask

   localparam coord_type MX = 32'sh7fffffff;
   localparam coord_type MN = 32'sh80000000;
   localparam coord_type ONE = 32'sh00010000;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: right triangle, all-zero, collinear, extremes, rounding ties.
      add_tri('{0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0});
      add_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      add_tri('{0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE});
      add_tri('{MN, MN, MN, MX, MN, MN, MN, MX, MN});
      add_tri('{MX, MX, MX, MN, MX, MX, MX, MN, MX});
      add_tri('{MN, MN, MN, MX, MX, MX, MN, MX, MN});
      add_tri('{MX, MN, 0, MN, MX, 0, MX, MX, MX});
      add_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0});
      add_tri('{0, 0, 0, 3, 0, 0, 0, 3, 0});
      add_tri('{-1, -1, -1, 0, -1, -1, -1, 0, -1});
      add_tri('{0, 0, 0, 1, 0, 0, 1000000, 1, 0});
      add_tri('{0, 0, 0, MX, 0, 0, 0, 1, 0});
      add_tri('{5, 7, 9, 5, 7, 9, 1, 2, 3});
      add_tri('{-32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
                32'shf0f0f0f0, 1, 2, 3, 4});
      wait_drained();

      // Pressure: hold the receiver off while the sender keeps offering.
      hold_req = 1'b1;
      add_random(150);
      wait_drained();

      add_random(800);
      wait_drained();

      quiet = 1'b1;
      add_random(250);
      wait_drained();

      repeat (LAT + 20) @(posedge clock);
      if (mismatches == 0 && centres_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #4000000;
      $display("tb: errors");
      $finish;
   end

endmodule
